### design/taabb_pkg.sv
package taabb_pkg;

    typedef logic signed [31:0] q_t;
    typedef q_t [2:0] vec3_t;
    typedef logic [30:0] size_t;
    typedef size_t [2:0] size3_t;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_TEST   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SIZE_X   = 3'd3,
        REG_SIZE_Y   = 3'd4,
        REG_SIZE_Z   = 3'd5
    } reg_idx_t;

    localparam int IDX_W = 3;
    localparam q_t Q_MAX = 32'sh7fff_ffff;
    localparam q_t Q_MIN = 32'sh8000_0000;

endpackage

### design/taabb_cfg.sv
module taabb_cfg
    import taabb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    output vec3_t            lo,
    output vec3_t            hi
);

    vec3_t  center_reg;
    vec3_t  center_next;
    size3_t size_reg;
    size3_t size_next;
    vec3_t  lo_reg;
    vec3_t  lo_next;
    vec3_t  hi_reg;
    vec3_t  hi_next;

    function automatic q_t sat33(input logic [32:0] v);
        q_t r;
        if (v[32] != v[31])
        begin
            r = v[32] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        center_next = center_reg;
        size_next   = size_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CENTER_X: center_next[0] = cfg_data;
                REG_CENTER_Y: center_next[1] = cfg_data;
                REG_CENTER_Z: center_next[2] = cfg_data;
                REG_SIZE_X:   size_next[0]   = cfg_data[30:0];
                REG_SIZE_Y:   size_next[1]   = cfg_data[30:0];
                REG_SIZE_Z:   size_next[2]   = cfg_data[30:0];
                default:      ;
            endcase
        end
        // corners follow the new value in the same edge as the write
        for (int a = 0; a < 3; a++)
        begin
            lo_next[a] = sat33({center_next[a][31], center_next[a]}
                               - {3'b000, size_next[a][30:1]});
            hi_next[a] = sat33({center_next[a][31], center_next[a]}
                               + {3'b000, size_next[a][30:1]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            size_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
        end
        else
        begin
            center_reg <= center_next;
            size_reg   <= size_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

### design/taabb_xform.sv
module taabb_xform
    import taabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_row,
    input  vec3_t      wr_data,
    input  vec3_t      lo,
    input  vec3_t      hi,
    output vec3_t      box_lo,
    output vec3_t      box_hi
);

    localparam int SH_W  = 64 - FRAC_BITS;
    localparam int SUM_W = SH_W + 2;

    vec3_t mat_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mat_reg[r] <= '0;
            end
        end
        else if (wr_en)
        begin
            mat_reg[wr_row] <= wr_data;
        end
    end

    // each corner picks lo or hi per axis on its own, so the extreme over
    // the eight corners is the sum of per-term extremes; the sign of the
    // matrix entry says which end gives the smaller product
    always_comb
    begin
        logic signed [63:0]      p_min;
        logic signed [63:0]      p_max;
        logic signed [SH_W-1:0]  t_min;
        logic signed [SH_W-1:0]  t_max;
        logic signed [SUM_W-1:0] s_min;
        logic signed [SUM_W-1:0] s_max;
        q_t                      m;
        q_t                      a_min;
        q_t                      a_max;
        box_lo = '0;
        box_hi = '0;
        for (int c = 0; c < 3; c++)
        begin
            s_min = {{(SUM_W-32){mat_reg[3][c][31]}}, mat_reg[3][c]};
            s_max = s_min;
            for (int r = 0; r < 3; r++)
            begin
                m     = mat_reg[r][c];
                a_min = m[31] ? hi[r] : lo[r];
                a_max = m[31] ? lo[r] : hi[r];
                p_min = a_min * m;
                p_max = a_max * m;
                // dropping low bits of a two's complement value floors it
                t_min = p_min[63:FRAC_BITS];
                t_max = p_max[63:FRAC_BITS];
                s_min = s_min + {{2{t_min[SH_W-1]}}, t_min};
                s_max = s_max + {{2{t_max[SH_W-1]}}, t_max};
            end
            if ((&s_min[SUM_W-1:31]) || !(|s_min[SUM_W-1:31]))
            begin
                box_lo[c] = s_min[31:0];
            end
            else
            begin
                box_lo[c] = s_min[SUM_W-1] ? Q_MIN : Q_MAX;
            end
            if ((&s_max[SUM_W-1:31]) || !(|s_max[SUM_W-1:31]))
            begin
                box_hi[c] = s_max[31:0];
            end
            else
            begin
                box_hi[c] = s_max[SUM_W-1] ? Q_MIN : Q_MAX;
            end
        end
    end

endmodule

### design/taabb_test.sv
module taabb_test
    import taabb_pkg::*;
(
    input  vec3_t box_lo,
    input  vec3_t box_hi,
    input  vec3_t other_lo,
    input  vec3_t other_hi,
    output logic  hit
);

    logic [2:0] axis_hit;

    // touching faces count as overlap
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            axis_hit[a] = !((box_hi[a] < other_lo[a]) || (box_lo[a] > other_hi[a]));
        end
    end

    assign hit = &axis_hit;

endmodule

### design/transformed_aabb_overlap.sv
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// in        in         in_valid / in_ready       op, row, row_x..z, other_min/max_x..z
// out       out        out_valid / out_ready     world_min/max_x..z, overlap
//
// one item per cycle sustained while out_ready stays high; the accepting edge loads the input
// register, and the result register loads from it when the item advances, which waits on
// out_ready, with the corner transform between the two registers
// rst_n clears config, matrix and world box to zero
// with out_ready low the result holds and one further item waits in the input register
// cfg_ready is always high
module transformed_aabb_overlap
    import taabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [1:0]       row,
    input  logic signed [31:0] row_x,
    input  logic signed [31:0] row_y,
    input  logic signed [31:0] row_z,
    input  logic signed [31:0] other_min_x,
    input  logic signed [31:0] other_min_y,
    input  logic signed [31:0] other_min_z,
    input  logic signed [31:0] other_max_x,
    input  logic signed [31:0] other_max_y,
    input  logic signed [31:0] other_max_z,
    output logic             out_valid,
    input  logic             out_ready,
    output logic signed [31:0] world_min_x,
    output logic signed [31:0] world_min_y,
    output logic signed [31:0] world_min_z,
    output logic signed [31:0] world_max_x,
    output logic signed [31:0] world_max_y,
    output logic signed [31:0] world_max_z,
    output logic             overlap
);

    logic       in_valid_reg;
    op_t        op_reg;
    logic [1:0] row_reg;
    vec3_t      row_data_reg;
    vec3_t      other_lo_reg;
    vec3_t      other_hi_reg;

    logic       out_valid_reg;
    vec3_t      world_lo_reg;
    vec3_t      world_hi_reg;
    logic       overlap_reg;

    vec3_t      corner_lo;
    vec3_t      corner_hi;
    vec3_t      box_lo;
    vec3_t      box_hi;
    logic       hit;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    taabb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lo        (corner_lo),
        .hi        (corner_hi)
    );

    taabb_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance && (op_reg == OP_LOAD)),
        .wr_row  (row_reg),
        .wr_data (row_data_reg),
        .lo      (corner_lo),
        .hi      (corner_hi),
        .box_lo  (box_lo),
        .box_hi  (box_hi)
    );

    taabb_test u_test (
        .box_lo   (world_lo_reg),
        .box_hi   (world_hi_reg),
        .other_lo (other_lo_reg),
        .other_hi (other_hi_reg),
        .hit      (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg       <= op_t'(op);
            row_reg      <= row;
            row_data_reg <= {row_z, row_y, row_x};
            other_lo_reg <= {other_min_z, other_min_y, other_min_x};
            other_hi_reg <= {other_max_z, other_max_y, other_max_x};
        end
    end

    // the world box registers are both the stored box and the result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            world_lo_reg  <= '0;
            world_hi_reg  <= '0;
            overlap_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            case (op_reg)
                OP_UPDATE:
                begin
                    world_lo_reg <= box_lo;
                    world_hi_reg <= box_hi;
                    overlap_reg  <= 1'b0;
                end
                OP_TEST:
                begin
                    overlap_reg <= hit;
                end
                default:
                begin
                    overlap_reg <= 1'b0;
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign world_min_x = world_lo_reg[0];
    assign world_min_y = world_lo_reg[1];
    assign world_min_z = world_lo_reg[2];
    assign world_max_x = world_hi_reg[0];
    assign world_max_y = world_hi_reg[1];
    assign world_max_z = world_hi_reg[2];
    assign overlap     = overlap_reg;

endmodule

### bench/box_checker.sv
module box_checker
    import taabb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       op,
    input  logic [1:0]       row,
    input  q_t               row_x,
    input  q_t               row_y,
    input  q_t               row_z,
    input  q_t               other_min_x,
    input  q_t               other_min_y,
    input  q_t               other_min_z,
    input  q_t               other_max_x,
    input  q_t               other_max_y,
    input  q_t               other_max_z,
    input  logic             out_valid,
    input  logic             out_ready,
    input  q_t               world_min_x,
    input  q_t               world_min_y,
    input  q_t               world_min_z,
    input  q_t               world_max_x,
    input  q_t               world_max_y,
    input  q_t               world_max_z,
    input  logic             overlap,
    output int               n_errors,
    output int               n_pending
);

    typedef struct {
        q_t   lo [3];
        q_t   hi [3];
        logic hit;
    } world_box_t;

    world_box_t boxes_due [$];

    q_t    center [3];
    size_t extent [3];
    q_t    matrix [12];
    q_t    world_lo [3];
    q_t    world_hi [3];
    string axis [3] = '{"x", "y", "z"};

    function automatic q_t clamp_q(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return q_t'(v);
    endfunction

    // one world coordinate of a local corner: floored products plus translation
    function automatic q_t corner_axis(input q_t c [3], input int col);
        longint acc;
        acc = longint'(matrix[9 + col]);
        for (int r = 0; r < 3; r++)
            acc += (longint'(c[r]) * longint'(matrix[r * 3 + col])) >>> FRAC_BITS;
        return clamp_q(acc);
    endfunction

    function automatic void refit_world_box();
        q_t     lo [3];
        q_t     hi [3];
        q_t     c [3];
        q_t     w;
        longint half;
        for (int a = 0; a < 3; a++)
        begin
            half  = longint'(extent[a] >> 1);
            lo[a] = clamp_q(longint'(center[a]) - half);
            hi[a] = clamp_q(longint'(center[a]) + half);
        end
        for (int k = 0; k < 8; k++)
        begin
            c[0] = ((k & 1) != 0) ? hi[0] : lo[0];
            c[1] = ((k & 2) != 0) ? hi[1] : lo[1];
            c[2] = ((k & 4) != 0) ? hi[2] : lo[2];
            for (int a = 0; a < 3; a++)
            begin
                w = corner_axis(c, a);
                if (k == 0 || w < world_lo[a])
                    world_lo[a] = w;
                if (k == 0 || w > world_hi[a])
                    world_hi[a] = w;
            end
        end
    endfunction

    task automatic report(input string what);
        if (n_errors < 100)
            $display("%0t: mismatch: %s", $time, what);
        n_errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        world_box_t due;
        q_t         got_lo [3];
        q_t         got_hi [3];
        q_t         other_lo [3];
        q_t         other_hi [3];
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                center[a]   = '0;
                extent[a]   = '0;
                world_lo[a] = '0;
                world_hi[a] = '0;
            end
            for (int i = 0; i < 12; i++)
                matrix[i] = '0;
            boxes_due.delete();
            n_errors  = 0;
            n_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CENTER_X: center[0] = cfg_data;
                    REG_CENTER_Y: center[1] = cfg_data;
                    REG_CENTER_Z: center[2] = cfg_data;
                    REG_SIZE_X:   extent[0] = cfg_data[30:0];
                    REG_SIZE_Y:   extent[1] = cfg_data[30:0];
                    REG_SIZE_Z:   extent[2] = cfg_data[30:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (boxes_due.size() == 0)
                    report("result with no item outstanding");
                else
                begin
                    due    = boxes_due.pop_front();
                    got_lo = '{world_min_x, world_min_y, world_min_z};
                    got_hi = '{world_max_x, world_max_y, world_max_z};
                    for (int a = 0; a < 3; a++)
                    begin
                        if (got_lo[a] !== due.lo[a])
                            report($sformatf("world_min_%s got %h want %h",
                                             axis[a], got_lo[a], due.lo[a]));
                        if (got_hi[a] !== due.hi[a])
                            report($sformatf("world_max_%s got %h want %h",
                                             axis[a], got_hi[a], due.hi[a]));
                    end
                    if (overlap !== due.hit)
                        report($sformatf("overlap got %b want %b", overlap, due.hit));
                end
            end

            if (in_valid && in_ready)
            begin
                other_lo = '{other_min_x, other_min_y, other_min_z};
                other_hi = '{other_max_x, other_max_y, other_max_z};
                due.hit  = 1'b0;
                case (op)
                    OP_LOAD:
                    begin
                        matrix[int'(row) * 3 + 0] = row_x;
                        matrix[int'(row) * 3 + 1] = row_y;
                        matrix[int'(row) * 3 + 2] = row_z;
                    end
                    OP_UPDATE:
                        refit_world_box();
                    OP_TEST:
                    begin
                        // touching boxes count, an inverted other box is taken as given
                        due.hit = 1'b1;
                        for (int a = 0; a < 3; a++)
                            if (world_hi[a] < other_lo[a] || world_lo[a] > other_hi[a])
                                due.hit = 1'b0;
                    end
                    default: ;
                endcase
                due.lo = world_lo;
                due.hi = world_hi;
                boxes_due.push_back(due);
            end

            n_pending = boxes_due.size();
        end
    end

endmodule

### bench/tb_top.sv
module tb_top;
    import taabb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 170;
    localparam q_t ONE         = 32'sh0001_0000;
    localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(REG_SIZE_Z + 1);

    typedef struct {
        op_t        code;
        logic [1:0] row;
        q_t         m [3];
        q_t         lo [3];
        q_t         hi [3];
    } box_cmd_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [31:0]      cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       op;
    logic [1:0]       row;
    q_t               row_x;
    q_t               row_y;
    q_t               row_z;
    q_t               other_min_x;
    q_t               other_min_y;
    q_t               other_min_z;
    q_t               other_max_x;
    q_t               other_max_y;
    q_t               other_max_z;
    logic             out_valid;
    logic             out_ready = 1'b0;
    q_t               world_min_x;
    q_t               world_min_y;
    q_t               world_min_z;
    q_t               world_max_x;
    q_t               world_max_y;
    q_t               world_max_z;
    logic             overlap;
    int               n_errors;
    int               n_pending;
    int               idle_cycles = 0;
    bit               calm = 1'b0;

    transformed_aabb_overlap i_dut (.*);

    box_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 35);

    // ends the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic q_t small_q(input int units);
        q_t v;
        v = $urandom_range(2 * units * 65536);
        return v - q_t'(units * 65536);
    endfunction

    function automatic q_t any_q();
        case ($urandom_range(4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic q_t pick_q(input bit wild, input int units);
        return wild ? any_q() : small_q(units);
    endfunction

    // fields the op does not use carry random bits
    function automatic box_cmd_t noise_cmd(input op_t code);
        box_cmd_t cmd;
        cmd.code = code;
        cmd.row  = $urandom_range(3);
        for (int a = 0; a < 3; a++)
        begin
            cmd.m[a]  = $urandom;
            cmd.lo[a] = $urandom;
            cmd.hi[a] = $urandom;
        end
        return cmd;
    endfunction

    function automatic box_cmd_t load_cmd(input int r, input q_t x, input q_t y, input q_t z);
        box_cmd_t cmd;
        cmd     = noise_cmd(OP_LOAD);
        cmd.row = 2'(r);
        cmd.m   = '{x, y, z};
        return cmd;
    endfunction

    function automatic box_cmd_t row_cmd(input int r, input bit wild);
        bit odd;
        odd = wild && ($urandom_range(2) == 0);
        if (r == 3)
            return load_cmd(r, pick_q(odd, 8), pick_q(odd, 8), pick_q(odd, 8));
        return load_cmd(r, pick_q(odd, 2), pick_q(odd, 2), pick_q(odd, 2));
    endfunction

    function automatic box_cmd_t test_cmd(input bit wild);
        box_cmd_t cmd;
        bit       odd;
        q_t       span;
        cmd = noise_cmd(OP_TEST);
        for (int a = 0; a < 3; a++)
        begin
            odd       = wild && ($urandom_range(3) == 0);
            cmd.lo[a] = pick_q(odd, 16);
            if ($urandom_range(9) == 0)
            begin
                span      = $urandom_range(4 * 65536);
                cmd.hi[a] = cmd.lo[a] - span;
            end
            else if (odd)
                cmd.hi[a] = any_q();
            else
            begin
                span      = $urandom_range(32 * 65536);
                cmd.hi[a] = cmd.lo[a] + span;
            end
        end
        return cmd;
    endfunction

    task automatic send(input box_cmd_t cmd);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= cmd.code;
        row         <= cmd.row;
        row_x       <= cmd.m[0];
        row_y       <= cmd.m[1];
        row_z       <= cmd.m[2];
        other_min_x <= cmd.lo[0];
        other_min_y <= cmd.lo[1];
        other_min_z <= cmd.lo[2];
        other_max_x <= cmd.hi[0];
        other_max_y <= cmd.hi[1];
        other_max_z <= cmd.hi[2];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // registers only change with the block idle
    task automatic set_box(input q_t c [3], input logic [31:0] s [3]);
        drain_results();
        write_reg(REG_CENTER_X, c[0]);
        write_reg(REG_CENTER_Y, c[1]);
        write_reg(REG_CENTER_Z, c[2]);
        write_reg(REG_SIZE_X, s[0]);
        write_reg(REG_SIZE_Y, s[1]);
        write_reg(REG_SIZE_Z, s[2]);
        if ($urandom_range(2) == 0)
            write_reg(IDX_W'(REG_SPARE + $urandom_range(1)), $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input bit wild);
        box_cmd_t cmd;
        int       sent;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(99) == 0)
                drain_results();
            if ($urandom_range(99) < 60)
            begin
                // rows, refit, then a few tests against the fresh box
                for (int r = 0; r < 4; r++)
                    if (r == 3 || $urandom_range(3) != 0)
                    begin
                        send(row_cmd(r, wild));
                        sent++;
                    end
                send(noise_cmd(OP_UPDATE));
                sent++;
                repeat ($urandom_range(1, 4))
                begin
                    send(test_cmd(wild));
                    sent++;
                end
            end
            else
            begin
                cmd = noise_cmd(op_t'($urandom_range(3)));
                if (cmd.code == OP_LOAD)
                    cmd = row_cmd(cmd.row, wild);
                else if (cmd.code == OP_TEST)
                    cmd = test_cmd(wild);
                send(cmd);
                sent++;
            end
        end
    endtask

    initial
    begin
        box_cmd_t    cmd;
        q_t          c3 [3];
        logic [31:0] s3 [3];
        bit          wild;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_CENTER_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = OP_NONE;
        row         = '0;
        row_x       = '0;
        row_y       = '0;
        row_z       = '0;
        other_min_x = '0;
        other_min_y = '0;
        other_min_z = '0;
        other_max_x = '0;
        other_max_y = '0;
        other_max_z = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // world box is still all zero here
        cmd    = noise_cmd(OP_TEST);
        cmd.lo = '{0, 0, 0};
        cmd.hi = '{0, 0, 0};
        send(cmd);
        cmd.lo = '{ONE, ONE, ONE};
        cmd.hi = '{2 * ONE, 2 * ONE, 2 * ONE};
        send(cmd);
        send(noise_cmd(OP_NONE));
        send(noise_cmd(OP_UPDATE));
        send(load_cmd(0, ONE, 0, 0));
        send(load_cmd(1, 0, ONE, 0));
        send(load_cmd(2, 0, 0, ONE));
        send(load_cmd(3, -ONE / 2, 3 * ONE, 0));
        c3 = '{ONE, -2 * ONE, 3 * ONE};
        s3 = '{3 * ONE + 1, 2 * ONE, 0};
        set_box(c3, s3);
        send(noise_cmd(OP_UPDATE));
        // touching faces, then an inverted box, then the full range
        cmd    = noise_cmd(OP_TEST);
        cmd.lo = '{2 * ONE, 2 * ONE, 3 * ONE};
        cmd.hi = '{5 * ONE, 5 * ONE, 3 * ONE};
        send(cmd);
        cmd.lo = '{ONE, ONE, 4 * ONE};
        cmd.hi = '{-ONE, -ONE, 2 * ONE};
        send(cmd);
        cmd.lo = '{Q_MIN, Q_MIN, Q_MIN};
        cmd.hi = '{Q_MAX, Q_MAX, Q_MAX};
        send(cmd);
        send(load_cmd(0, Q_MAX, Q_MIN, -1));
        send(load_cmd(3, Q_MAX, Q_MIN, 32'sh7000_0000));
        c3 = '{Q_MAX, Q_MIN, -1};
        s3 = '{32'h7fff_ffff, 32'hffff_ffff, 1};
        set_box(c3, s3);
        // new registers only apply at the next refit
        send(noise_cmd(OP_TEST));
        send(noise_cmd(OP_UPDATE));
        send(load_cmd(1, -1, 1, Q_MIN));
        send(load_cmd(2, -ONE, 32'sh0000_8000, Q_MAX));
        send(noise_cmd(OP_UPDATE));
        cmd    = noise_cmd(OP_TEST);
        cmd.lo = '{Q_MAX, Q_MAX, Q_MAX};
        cmd.hi = '{Q_MAX, Q_MAX, Q_MAX};
        send(cmd);
        cmd     = noise_cmd(OP_NONE);
        cmd.row = 2'b11;
        send(cmd);

        for (int p = 0; p < PHASES; p++)
        begin
            wild = (p % 4 == 3);
            for (int a = 0; a < 3; a++)
            begin
                c3[a] = wild ? any_q() : small_q(4);
                s3[a] = wild ? $urandom : $urandom_range(8 * 65536);
            end
            set_box(c3, s3);
            calm = (p == 4);
            run_phase(wild);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
